>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Implication style property, checked at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

>>> hdl/ccl_pkg.sv
package ccl_pkg;

   localparam int TIME_WIDTH_DEFAULT = 32;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam int LEVEL_W    = 16;
   localparam int NOW_W      = 32;
   localparam int CFG_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CLS_W      = 3;

   // per-mille division: quotient never exceeds 1000
   localparam int PERMILLE   = 1000;
   localparam int QUOT_W     = 10;
   localparam int QSTEPS     = 10;
   localparam int STEP_W     = 4;
   localparam int SUM_W      = 18;
   localparam int DIVIDEND_W = 26;
   localparam int CMP_W      = QUOT_W + 1;

   // classification thresholds, in per-mille
   localparam logic [CMP_W-1:0] TH_WHITE_LO  = CMP_W'(250);
   localparam logic [CMP_W-1:0] TH_WHITE_HI  = CMP_W'(400);
   localparam logic [CMP_W-1:0] TH_RED_MIN   = CMP_W'(430);
   localparam logic [CMP_W-1:0] TH_RED_GAP   = CMP_W'(80);
   localparam logic [CMP_W-1:0] TH_GREEN_MIN = CMP_W'(400);
   localparam logic [CMP_W-1:0] TH_BLUE_MIN  = CMP_W'(390);
   localparam logic [CMP_W-1:0] TH_GB_GAP    = CMP_W'(70);
   localparam logic [CMP_W-1:0] TH_YEL_RG    = CMP_W'(330);
   localparam logic [CMP_W-1:0] TH_YEL_B     = CMP_W'(280);

   typedef enum logic [CLS_W-1:0] {
      CLS_NONE    = 3'd0,
      CLS_UNKNOWN = 3'd1,
      CLS_WHITE   = 3'd2,
      CLS_RED     = 3'd3,
      CLS_GREEN   = 3'd4,
      CLS_BLUE    = 3'd5,
      CLS_YELLOW  = 3'd6
   } color_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_CLEAR       = 3'd0,
      CSR_WHITE_MIN_CLEAR = 3'd1,
      CSR_STABLE_TIME     = 3'd2,
      CSR_RELEASE_TIME    = 3'd3,
      CSR_REST_COMPARE    = 3'd4,
      CSR_ACTIVE_COMPARE  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [CFG_W-1:0] min_clear;
      logic [CFG_W-1:0] white_min_clear;
      logic [CFG_W-1:0] stable_time_ms;
      logic [CFG_W-1:0] release_time_ms;
      logic [CFG_W-1:0] rest_compare;
      logic [CFG_W-1:0] active_compare;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      min_clear:       16'd80,
      white_min_clear: 16'd600,
      stable_time_ms:  16'd2000,
      release_time_ms: 16'd500,
      rest_compare:    16'd150,
      active_compare:  16'd200
   };

   typedef enum logic [2:0] {
      FE_IDLE,
      FE_SUM,
      FE_LOAD,
      FE_DIV,
      FE_CLASS
   } front_state_type;

endpackage

>>> hdl/ccl_front.sv
module ccl_front import ccl_pkg::*; #(
   parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [LEVEL_W-1:0]    req_clear_level,
   input  logic [LEVEL_W-1:0]    req_red_level,
   input  logic [LEVEL_W-1:0]    req_green_level,
   input  logic [LEVEL_W-1:0]    req_blue_level,
   input  logic [NOW_W-1:0]      req_now_ms,
   output logic                  push,
   input  logic                  queue_full,
   output color_type             push_cls,
   output logic [TIME_WIDTH-1:0] push_now
);

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   front_state_type state_ff, state_in;

   logic [LEVEL_W-1:0]    clear_ff, red_ff, green_ff, blue_ff;
   logic [TIME_WIDTH-1:0] now_ff;
   logic [TIME_WIDTH-1:0] now_ext;
   logic [SUM_W-1:0]      sum_ff;
   logic [DIVIDEND_W-1:0] rem_ff;
   logic [QUOT_W-1:0]     q_ff;
   logic [STEP_W-1:0]     step_ff;
   logic [1:0]            ch_ff;
   logic [QUOT_W-1:0]     rn_ff, gn_ff, bn_ff;

   logic [LEVEL_W-1:0]    chan_sel;
   logic [DIVIDEND_W:0]   div_shift;
   logic                  div_ge;
   logic [QUOT_W-1:0]     q_next;
   color_type             cls;

   generate
      if (TIME_WIDTH <= NOW_W) begin : g_now_trunc
         assign now_ext = req_now_ms[TIME_WIDTH-1:0];
      end else begin : g_now_ext
         assign now_ext = {{(TIME_WIDTH-NOW_W){1'b0}}, req_now_ms};
      end
   endgenerate

   always_comb begin
      case (ch_ff)
         CH_RED:   chan_sel = red_ff;
         CH_GREEN: chan_sel = green_ff;
         CH_BLUE:  chan_sel = blue_ff;
         default:  chan_sel = blue_ff;
      endcase
   end

   // one restoring step: try divisor << step against the remainder
   assign div_shift = (DIVIDEND_W+1)'(sum_ff) << step_ff;
   assign div_ge    = {1'b0, rem_ff} >= div_shift;
   assign q_next    = {q_ff[QUOT_W-2:0], div_ge};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FE_IDLE:  if (req_valid) state_in = FE_SUM;
         FE_SUM:   state_in = FE_LOAD;
         FE_LOAD:  state_in = FE_DIV;
         FE_DIV: begin
            if (step_ff == '0) begin
               state_in = (ch_ff == CH_BLUE) ? FE_CLASS : FE_LOAD;
            end
         end
         FE_CLASS: if (!queue_full) state_in = FE_IDLE;
         default:  state_in = FE_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      push      = 1'b0;
      case (state_ff)
         FE_IDLE:  req_ready = 1'b1;
         FE_CLASS: push      = !queue_full;
         default: begin
            req_ready = 1'b0;
            push      = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         FE_IDLE: begin
            if (req_valid) begin
               clear_ff <= req_clear_level;
               red_ff   <= req_red_level;
               green_ff <= req_green_level;
               blue_ff  <= req_blue_level;
               now_ff   <= now_ext;
            end
         end
         FE_SUM: begin
            sum_ff <= SUM_W'(red_ff) + SUM_W'(green_ff) + SUM_W'(blue_ff);
            ch_ff  <= CH_RED;
         end
         FE_LOAD: begin
            rem_ff  <= DIVIDEND_W'(chan_sel) * DIVIDEND_W'(PERMILLE);
            step_ff <= STEP_W'(QSTEPS - 1);
            q_ff    <= '0;
         end
         FE_DIV: begin
            if (div_ge) rem_ff <= rem_ff - div_shift[DIVIDEND_W-1:0];
            q_ff <= q_next;
            if (step_ff == '0) begin
               case (ch_ff)
                  CH_RED:   rn_ff <= q_next;
                  CH_GREEN: gn_ff <= q_next;
                  default:  bn_ff <= q_next;
               endcase
               ch_ff <= ch_ff + 2'd1;
            end else begin
               step_ff <= step_ff - STEP_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // threshold tests on the per-mille shares
   always_comb begin
      logic [CMP_W-1:0] rn, gn, bn;
      rn = CMP_W'(rn_ff);
      gn = CMP_W'(gn_ff);
      bn = CMP_W'(bn_ff);
      if (clear_ff < cfg.min_clear || sum_ff == '0) begin
         cls = CLS_NONE;
      end else if (clear_ff > cfg.white_min_clear &&
                   rn > TH_WHITE_LO && rn < TH_WHITE_HI &&
                   gn > TH_WHITE_LO && gn < TH_WHITE_HI &&
                   bn > TH_WHITE_LO && bn < TH_WHITE_HI) begin
         cls = CLS_WHITE;
      end else if (rn > TH_RED_MIN && rn > gn + TH_RED_GAP && rn > bn + TH_RED_GAP) begin
         cls = CLS_RED;
      end else if (gn > TH_GREEN_MIN && gn > rn + TH_GB_GAP && gn > bn + TH_GB_GAP) begin
         cls = CLS_GREEN;
      end else if (bn > TH_BLUE_MIN && bn > rn + TH_GB_GAP && bn > gn + TH_GB_GAP) begin
         cls = CLS_BLUE;
      end else if (rn > TH_YEL_RG && gn > TH_YEL_RG && bn < TH_YEL_B) begin
         cls = CLS_YELLOW;
      end else begin
         cls = CLS_UNKNOWN;
      end
   end

   assign push_cls = cls;
   assign push_now = now_ff;

endmodule

>>> hdl/ccl_queue.sv
module ccl_queue import ccl_pkg::*; #(
   parameter int WIDTH = CLS_W + TIME_WIDTH_DEFAULT,
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output logic [WIDTH-1:0] rdata
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign full    = count_ff == CNT_W'(DEPTH);
   assign valid   = count_ff != '0;
   assign do_push = push && !full;
   assign do_pop  = pop && valid;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

>>> hdl/ccl_latch.sv
module ccl_latch import ccl_pkg::*; #(
   parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  item_valid,
   input  color_type             item_cls,
   input  logic [TIME_WIDTH-1:0] item_now,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CLS_W-1:0]      rsp_color_class,
   output logic [CLS_W-1:0]      rsp_confirmed_color,
   output logic [CFG_W-1:0]      rsp_servo_compare,
   output logic                  rsp_servo_active,
   output logic                  rsp_confirm_event,
   output logic                  rsp_waiting_release
);

   color_type             held_ff, held_in;
   logic                  servo_ff, servo_in;
   color_type             cand_ff, cand_in;
   logic [TIME_WIDTH-1:0] cand_since_ff, cand_since_in;
   logic                  await_ff, await_in;
   logic [TIME_WIDTH-1:0] rel_since_ff, rel_since_in;
   logic                  rel_timing_ff, rel_timing_in;
   logic                  event_in;

   logic                  no_color;
   logic [TIME_WIDTH-1:0] rel_start;
   logic                  rel_done, stable_done;

   logic                  rsp_valid_ff;
   logic [CLS_W-1:0]      cls_ff, confirmed_ff;
   logic [CFG_W-1:0]      compare_ff;
   logic                  servo_out_ff, event_ff, waiting_ff;

   assign pop      = item_valid && (!rsp_valid_ff || rsp_ready);
   assign no_color = item_cls inside {CLS_NONE, CLS_UNKNOWN};

   // elapsed times wrap modulo 2^TIME_WIDTH
   assign rel_start   = rel_timing_ff ? rel_since_ff : item_now;
   assign rel_done    = (item_now - rel_start) >= TIME_WIDTH'(cfg.release_time_ms);
   assign stable_done = (item_now - cand_since_ff) >= TIME_WIDTH'(cfg.stable_time_ms);

   always_comb begin
      held_in       = held_ff;
      servo_in      = servo_ff;
      cand_in       = cand_ff;
      cand_since_in = cand_since_ff;
      await_in      = await_ff;
      rel_since_in  = rel_since_ff;
      rel_timing_in = rel_timing_ff;
      event_in      = 1'b0;
      if (await_ff) begin
         if (no_color) begin
            rel_since_in  = rel_start;
            rel_timing_in = 1'b1;
            if (rel_done) begin
               await_in      = 1'b0;
               rel_timing_in = 1'b0;
               rel_since_in  = '0;
               cand_in       = CLS_NONE;
               cand_since_in = '0;
            end
         end else begin
            rel_timing_in = 1'b0;
            rel_since_in  = '0;
         end
      end else if (no_color) begin
         cand_in       = CLS_NONE;
         cand_since_in = '0;
      end else if (item_cls != cand_ff) begin
         cand_in       = item_cls;
         cand_since_in = item_now;
      end else if (stable_done) begin
         if (held_ff != CLS_NONE && item_cls == held_ff) begin
            servo_in = !servo_ff;
         end else begin
            held_in  = item_cls;
            servo_in = 1'b1;
         end
         event_in      = 1'b1;
         await_in      = 1'b1;
         rel_timing_in = 1'b0;
         rel_since_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff       <= CLS_NONE;
         servo_ff      <= 1'b0;
         cand_ff       <= CLS_NONE;
         cand_since_ff <= '0;
         await_ff      <= 1'b0;
         rel_since_ff  <= '0;
         rel_timing_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (pop) begin
            held_ff       <= held_in;
            servo_ff      <= servo_in;
            cand_ff       <= cand_in;
            cand_since_ff <= cand_since_in;
            await_ff      <= await_in;
            rel_since_ff  <= rel_since_in;
            rel_timing_ff <= rel_timing_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cls_ff       <= item_cls;
         confirmed_ff <= held_in;
         compare_ff   <= servo_in ? cfg.active_compare : cfg.rest_compare;
         servo_out_ff <= servo_in;
         event_ff     <= event_in;
         waiting_ff   <= await_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_color_class     = cls_ff;
   assign rsp_confirmed_color = confirmed_ff;
   assign rsp_servo_compare   = compare_ff;
   assign rsp_servo_active    = servo_out_ff;
   assign rsp_confirm_event   = event_ff;
   assign rsp_waiting_release = waiting_ff;

endmodule

>>> hdl/color_classify_and_latch_core.sv
// Color sample classifier with a stable-time latch that drives a two-position
// servo. Each request transaction carries clear/red/green/blue counts and a
// millisecond timestamp; each one yields exactly one response transaction with
// the sample's class, the held color, the servo compare value and flags. One
// sample occupies the front end through accept, forming r+g+b, then for red,
// green and blue each a load step and ten quotient bits from the shared
// restoring divider, and a classify step that waits while the queue is full.
// The back end settles the latch per popped sample; a two-entry queue between
// them lets the front take the next sample while a response is still waiting.
// The user writes the csr_ port (index, data) registers only while idle; the
// block does not enforce it. Unknown indexes are ignored. No clearing after reset.

`include "assert_macros.svh"

module color_classify_and_latch_core import ccl_pkg::*; #(
   parameter int TIME_WIDTH  = TIME_WIDTH_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   // configuration write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   // request (sample) channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [LEVEL_W-1:0]   req_clear_level,
   input  logic [LEVEL_W-1:0]   req_red_level,
   input  logic [LEVEL_W-1:0]   req_green_level,
   input  logic [LEVEL_W-1:0]   req_blue_level,
   input  logic [NOW_W-1:0]     req_now_ms,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [CLS_W-1:0]     rsp_color_class,
   output logic [CLS_W-1:0]     rsp_confirmed_color,
   output logic [CFG_W-1:0]     rsp_servo_compare,
   output logic                 rsp_servo_active,
   output logic                 rsp_confirm_event,
   output logic                 rsp_waiting_release
);

   localparam int ITEM_W = CLS_W + TIME_WIDTH;

   cfg_type               cfg_ff;

   // front end -> queue
   logic                  push;
   logic                  queue_full;
   color_type             push_cls;
   logic [TIME_WIDTH-1:0] push_now;
   logic [ITEM_W-1:0]     queue_wdata;

   // queue -> back end
   logic                  pop;
   logic                  queue_valid;
   logic [ITEM_W-1:0]     queue_rdata;
   color_type             item_cls;
   logic [TIME_WIDTH-1:0] item_now;

   // Configuration registers: always ready, unknown indexes dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MIN_CLEAR:       cfg_ff.min_clear       <= csr_wdata;
            CSR_WHITE_MIN_CLEAR: cfg_ff.white_min_clear <= csr_wdata;
            CSR_STABLE_TIME:     cfg_ff.stable_time_ms  <= csr_wdata;
            CSR_RELEASE_TIME:    cfg_ff.release_time_ms <= csr_wdata;
            CSR_REST_COMPARE:    cfg_ff.rest_compare    <= csr_wdata;
            CSR_ACTIVE_COMPARE:  cfg_ff.active_compare  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Front end: capture, per-mille division, threshold classification.
   ccl_front #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_clear_level (req_clear_level),
      .req_red_level   (req_red_level),
      .req_green_level (req_green_level),
      .req_blue_level  (req_blue_level),
      .req_now_ms      (req_now_ms),
      .push            (push),
      .queue_full      (queue_full),
      .push_cls        (push_cls),
      .push_now        (push_now)
   );

   // Classified samples wait here: class on top, timestamp below.
   assign queue_wdata = {push_cls, push_now};

   ccl_queue #(
      .WIDTH (ITEM_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (queue_wdata),
      .full  (queue_full),
      .pop   (pop),
      .valid (queue_valid),
      .rdata (queue_rdata)
   );

   assign item_cls = color_type'(queue_rdata[ITEM_W-1 -: CLS_W]);
   assign item_now = queue_rdata[TIME_WIDTH-1:0];

   // Back end: candidate/confirm/release latch and the response register.
   ccl_latch #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_latch (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .item_valid          (queue_valid),
      .item_cls            (item_cls),
      .item_now            (item_now),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_color_class     (rsp_color_class),
      .rsp_confirmed_color (rsp_confirmed_color),
      .rsp_servo_compare   (rsp_servo_compare),
      .rsp_servo_active    (rsp_servo_active),
      .rsp_confirm_event   (rsp_confirm_event),
      .rsp_waiting_release (rsp_waiting_release)
   );

   // A confirmation always arms the release wait.
   `ASSERT_CLK(a_confirm_arms_release, clock, reset,
      (rsp_valid && rsp_confirm_event) |-> rsp_waiting_release,
      "confirmation without release wait")

   // The confirmed color is the sample's own class.
   `ASSERT_CLK(a_confirm_matches_class, clock, reset,
      (rsp_valid && rsp_confirm_event) |-> (rsp_confirmed_color == rsp_color_class),
      "confirmed color differs from sample class")

   // The servo can only be active once some color has been held.
   `ASSERT_NEVER(a_servo_needs_color, clock, reset,
      rsp_valid && rsp_servo_active && (rsp_confirmed_color == CLS_NONE),
      "servo active with no held color")

   // The front end is busy right after it takes a transaction.
   `ASSERT_CLK(a_front_busy_after_accept, clock, reset,
      (req_valid && req_ready) |=> !req_ready,
      "front end ready again right after accept")

endmodule
